[sv/tcpq_pkg.sv]
`default_nettype none

package tcpq_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic CLASS_LOW  = 1'b0;
    localparam logic CLASS_HIGH = 1'b1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd60;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BOTH_FULL = 3'd1,
        STATUS_HIGH_FULL = 3'd2,
        STATUS_LOW_FULL  = 3'd3,
        STATUS_EMPTY     = 3'd4
    } tcpq_status_t;

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } tcpq_in_t;

    typedef struct packed {
        tcpq_status_t status;
        logic [7:0]   removed_value;
        logic         removed_class;
        logic [3:0]   high_count;
        logic [3:0]   low_count;
    } tcpq_out_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tcpq_flags_t;

endpackage

`default_nettype wire

[sv/tcpq_fifo.sv]
`default_nettype none

module tcpq_fifo #(
    parameter int unsigned DEPTH = 8,
    localparam int unsigned PW = $clog2(DEPTH),
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic                  pop,
    input  wire logic [7:0]            wr_data,
    output logic [7:0]                 rd_data,
    output tcpq_pkg::tcpq_flags_t      flags,
    output logic [CW-1:0]              count_next
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW:0]   tail_sum;
    logic [CW:0]   tail_wrap;
    logic [PW-1:0] tail;

    // tail = (head + count) mod depth, sum stays below twice the depth
    assign tail_sum  = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= (CW + 1)'(DEPTH)) ? tail_sum - (CW + 1)'(DEPTH) : tail_sum;
    assign tail      = tail_wrap[PW-1:0];

    assign head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign flags.full  = (count_reg == CW'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign rd_data     = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
            begin
                head_reg <= head_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail] <= wr_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

endmodule

`default_nettype wire

[sv/two_class_priority_queue.sv]
`default_nettype none

// two-class strict priority queue
// in channel (in_valid/in_ready/in_data): op push or pop, plus value for a push.
// a pushed value at or above the threshold joins the high fifo, otherwise the low
// fifo; a pop takes the oldest high entry, else the oldest low entry.
// every item gives exactly one result on the out channel: status, removed value
// and class, and both occupancies after the operation.
// cfg channel writes the 8-bit class threshold (reset 60); always ready, write
// it only while the block is idle.
// an accepted item is registered in the fifo memory read register, then in the
// output register. one item is taken every cycle while out_ready stays high.
// when the receiver stalls, the output register holds and the read stage fills;
// in_ready then drops until out_ready returns.
// reset empties both fifos and restores the threshold; stored entries are not
// cleared and the block takes items right after reset.
module two_class_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tcpq_pkg::tcpq_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tcpq_pkg::tcpq_out_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    tcpq_pkg::tcpq_flags_t  high_flags;
    tcpq_pkg::tcpq_flags_t  low_flags;
    logic [7:0]             high_rd;
    logic [7:0]             low_rd;
    logic [CW-1:0]          high_count_next;
    logic [CW-1:0]          low_count_next;
    logic [CW+3:0]          high_count_ext;
    logic [CW+3:0]          low_count_ext;

    logic [7:0]             threshold_reg;
    logic                   accept;
    logic                   is_high;
    logic                   push_high;
    logic                   push_low;
    logic                   pop_high;
    logic                   pop_low;
    tcpq_pkg::tcpq_status_t status;

    logic                   s1_valid_reg;
    tcpq_pkg::tcpq_status_t s1_status_reg;
    logic                   s1_took_reg;
    logic                   s1_class_reg;
    logic [3:0]             s1_high_count_reg;
    logic [3:0]             s1_low_count_reg;
    logic                   s2_free;
    logic                   advance;

    logic                   out_valid_reg;
    tcpq_pkg::tcpq_out_t    out_data_reg;
    tcpq_pkg::tcpq_out_t    out_data_next;

    assign s2_free   = !out_valid_reg || out_ready;
    assign advance   = s1_valid_reg && s2_free;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign is_high = (in_data.value >= threshold_reg);

    always_comb
    begin
        push_high = 1'b0;
        push_low  = 1'b0;
        pop_high  = 1'b0;
        pop_low   = 1'b0;
        status    = tcpq_pkg::STATUS_OK;
        if (in_data.op == tcpq_pkg::OP_PUSH)
        begin
            if (high_flags.full && low_flags.full)
            begin
                status = tcpq_pkg::STATUS_BOTH_FULL;
            end
            else if (is_high)
            begin
                if (high_flags.full)
                begin
                    status = tcpq_pkg::STATUS_HIGH_FULL;
                end
                else
                begin
                    push_high = accept;
                end
            end
            else
            begin
                if (low_flags.full)
                begin
                    status = tcpq_pkg::STATUS_LOW_FULL;
                end
                else
                begin
                    push_low = accept;
                end
            end
        end
        else
        begin
            if (!high_flags.empty)
            begin
                pop_high = accept;
            end
            else if (!low_flags.empty)
            begin
                pop_low = accept;
            end
            else
            begin
                status = tcpq_pkg::STATUS_EMPTY;
            end
        end
    end

    tcpq_fifo #(
        .DEPTH      (QUEUE_DEPTH)
    ) u_high_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_high),
        .pop        (pop_high),
        .wr_data    (in_data.value),
        .rd_data    (high_rd),
        .flags      (high_flags),
        .count_next (high_count_next)
    );

    tcpq_fifo #(
        .DEPTH      (QUEUE_DEPTH)
    ) u_low_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_low),
        .pop        (pop_low),
        .wr_data    (in_data.value),
        .rd_data    (low_rd),
        .flags      (low_flags),
        .count_next (low_count_next)
    );

    // reported counts keep only the low four bits
    assign high_count_ext = {4'b0, high_count_next};
    assign low_count_ext  = {4'b0, low_count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tcpq_pkg::THRESHOLD_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                threshold_reg <= cfg_data;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg     <= status;
            s1_took_reg       <= pop_high || pop_low;
            s1_class_reg      <= pop_high ? tcpq_pkg::CLASS_HIGH : tcpq_pkg::CLASS_LOW;
            s1_high_count_reg <= high_count_ext[3:0];
            s1_low_count_reg  <= low_count_ext[3:0];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        out_data_next.status        = s1_status_reg;
        out_data_next.removed_class = s1_took_reg ? s1_class_reg : tcpq_pkg::CLASS_LOW;
        out_data_next.high_count    = s1_high_count_reg;
        out_data_next.low_count     = s1_low_count_reg;
        if (!s1_took_reg)
        begin
            out_data_next.removed_value = '0;
        end
        else if (s1_class_reg == tcpq_pkg::CLASS_HIGH)
        begin
            out_data_next.removed_value = high_rd;
        end
        else
        begin
            out_data_next.removed_value = low_rd;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
